// ----- rtl/core/ole_pkg.sv -----
// package for the ordered list engine: defaults, action and status codes, control states
`default_nettype none

package ole_pkg;

  localparam int unsigned CAPACITY_DEF   = 1024;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned POSITION_W = 11;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned LENGTH_W   = 11;

  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_INSERT     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_ALLOC,
    S_INS,
    S_INS2,
    S_PF,
    S_FVAL,
    S_PB,
    S_BVAL,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/core/ordered_list_engine_core.sv -----
// ordered list engine: singly linked list of values kept in a slot pool in two memories
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+------------------------
//  command   | action_i, value_i, position_i                 | start_i while busy_o low
//  result    | status_o, length_o, front_value_o, back_value_o | done_o, one cycle, no stall
//
// after accept, errors and single-entry pops go from the check straight to the response;
// pushes and end inserts allocate a slot first; back pop and middle insert walk the link
// memory one hop a cycle, each hop a dependent synchronous read.
// busy_o stays high until the cycle after done_o; reset empties the list at once,
// the value and link memories need no clearing.
`default_nettype none

module ordered_list_engine_core #(
  parameter int unsigned CAPACITY   = ole_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = ole_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [ole_pkg::ACTION_W-1:0]        action_i,
  input  logic signed [ole_pkg::VALUE_W-1:0]  value_i,
  input  logic [ole_pkg::POSITION_W-1:0]      position_i,
  output logic                                done_o,
  output logic [ole_pkg::STATUS_W-1:0]        status_o,
  output logic [ole_pkg::LENGTH_W-1:0]        length_o,
  output logic signed [ole_pkg::VALUE_W-1:0]  front_value_o,
  output logic signed [ole_pkg::VALUE_W-1:0]  back_value_o
);

  import ole_pkg::*;

  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e state_q, state_d;

  logic [ACTION_W-1:0]   act_q;
  logic [VALUE_W-1:0]    val_q;
  logic [POSITION_W-1:0] pos_q;
  logic [STATUS_W-1:0]   status_q, status_d;

  logic [SW-1:0] first_q, first_d;
  logic [SW-1:0] last_q, last_d;
  logic [SW-1:0] free_head_q, free_head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] nu_q, nu_d;
  logic [SW-1:0] cur_q, cur_d;
  logic [CW-1:0] steps_q, steps_d;
  logic [SW-1:0] slot_q, slot_d;

  logic [VALUE_BITS-1:0] front_val_q, front_val_d;
  logic [VALUE_BITS-1:0] back_val_q, back_val_d;

  logic [VALUE_BITS-1:0] val_mem [CAPACITY];
  logic [SW-1:0]         link_mem [CAPACITY];

  logic                  val_we;
  logic [SW-1:0]         val_waddr;
  logic [SW-1:0]         val_raddr;
  logic [VALUE_BITS-1:0] val_rdata;
  logic                  link_we;
  logic [SW-1:0]         link_waddr;
  logic [SW-1:0]         link_wdata;
  logic [SW-1:0]         link_raddr;
  logic [SW-1:0]         link_rdata;

  logic [63:0]           val_wide;
  logic [VALUE_BITS-1:0] val_in;
  logic [63:0]           front_ext;
  logic [63:0]           back_ext;

  logic [STATUS_W-1:0] chk_status;
  logic                is_full;
  logic                is_empty;
  logic                at_front;
  logic                at_back;
  logic                pool_fresh;
  logic [SW-1:0]       new_slot;

  assign val_wide   = 64'(val_q);
  assign val_in     = val_wide[VALUE_BITS-1:0];
  assign is_full    = 32'(count_q) >= CAPACITY;
  assign is_empty   = (count_q == '0);
  assign at_front   = (act_q == ACT_PUSH_FRONT) || ((act_q == ACT_INSERT) && (pos_q == '0));
  assign at_back    = (act_q == ACT_PUSH_BACK)
                   || ((act_q == ACT_INSERT) && (32'(pos_q) == 32'(count_q)));
  assign pool_fresh = 32'(nu_q) < CAPACITY;
  assign new_slot   = pool_fresh ? nu_q[SW-1:0] : free_head_q;

  always_comb begin
    case (act_q)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: chk_status = is_full ? ST_FULL : ST_OK;
      ACT_POP_FRONT, ACT_POP_BACK:   chk_status = is_empty ? ST_EMPTY : ST_OK;
      ACT_INSERT: begin
        if (32'(pos_q) > 32'(count_q)) begin
          chk_status = ST_INVALID;
        end else if (is_full) begin
          chk_status = ST_FULL;
        end else begin
          chk_status = ST_OK;
        end
      end
      default: chk_status = ST_INVALID;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (chk_status != ST_OK) begin
          state_d = S_RESP;
        end else begin
          case (act_q)
            ACT_POP_FRONT: state_d = (count_q == CW'(1)) ? S_RESP : S_PF;
            ACT_POP_BACK: begin
              if (count_q == CW'(1)) begin
                state_d = S_RESP;
              end else if (count_q == CW'(2)) begin
                state_d = S_PB;
              end else begin
                state_d = S_WALK;
              end
            end
            ACT_INSERT: begin
              if (at_front || at_back || (pos_q == POSITION_W'(1))) begin
                state_d = S_ALLOC;
              end else begin
                state_d = S_WALK;
              end
            end
            default: state_d = S_ALLOC;
          endcase
        end
      end
      S_WALK: begin
        if (steps_q == CW'(1)) begin
          state_d = (act_q == ACT_POP_BACK) ? S_PB : S_ALLOC;
        end
      end
      S_ALLOC: state_d = (at_front || at_back) ? S_RESP : S_INS;
      S_INS:   state_d = S_INS2;
      S_INS2:  state_d = S_RESP;
      S_PF:    state_d = S_FVAL;
      S_FVAL:  state_d = S_RESP;
      S_PB:    state_d = S_BVAL;
      S_BVAL:  state_d = S_RESP;
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    status_d    = status_q;
    first_d     = first_q;
    last_d      = last_q;
    free_head_d = free_head_q;
    count_d     = count_q;
    nu_d        = nu_q;
    cur_d       = cur_q;
    steps_d     = steps_q;
    slot_d      = slot_q;
    front_val_d = front_val_q;
    back_val_d  = back_val_q;
    val_we      = 1'b0;
    val_waddr   = new_slot;
    val_raddr   = cur_q;
    link_we     = 1'b0;
    link_waddr  = first_q;
    link_wdata  = free_head_q;
    link_raddr  = free_head_q;
    case (state_q)
      S_CHECK: begin
        status_d = chk_status;
        if (chk_status == ST_OK) begin
          case (act_q)
            ACT_POP_FRONT, ACT_POP_BACK: begin
              if (count_q == CW'(1)) begin
                link_we     = 1'b1;
                free_head_d = first_q;
                first_d     = '0;
                last_d      = '0;
                count_d     = '0;
              end else if (act_q == ACT_POP_FRONT) begin
                link_raddr = first_q;
              end else begin
                cur_d      = first_q;
                steps_d    = count_q - CW'(2);
                link_raddr = first_q;
              end
            end
            ACT_INSERT: begin
              cur_d = first_q;
              if (!at_front && !at_back && (pos_q != POSITION_W'(1))) begin
                steps_d    = CW'(pos_q) - CW'(1);
                link_raddr = first_q;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        cur_d   = link_rdata;
        steps_d = steps_q - CW'(1);
        if (steps_q != CW'(1)) begin
          link_raddr = link_rdata;
        end
      end
      S_ALLOC: begin
        slot_d = new_slot;
        if (pool_fresh) begin
          nu_d = nu_q + CW'(1);
        end else begin
          free_head_d = link_rdata;
        end
        val_we = 1'b1;
        if (at_front) begin
          link_we     = 1'b1;
          link_waddr  = new_slot;
          link_wdata  = first_q;
          first_d     = new_slot;
          front_val_d = val_in;
          if (is_empty) begin
            last_d     = new_slot;
            back_val_d = val_in;
          end
          count_d = count_q + CW'(1);
        end else if (at_back) begin
          if (is_empty) begin
            first_d     = new_slot;
            front_val_d = val_in;
          end else begin
            link_we    = 1'b1;
            link_waddr = last_q;
            link_wdata = new_slot;
          end
          last_d     = new_slot;
          back_val_d = val_in;
          count_d    = count_q + CW'(1);
        end else begin
          link_raddr = cur_q;
        end
      end
      S_INS: begin
        link_we    = 1'b1;
        link_waddr = slot_q;
        link_wdata = link_rdata;
      end
      S_INS2: begin
        link_we    = 1'b1;
        link_waddr = cur_q;
        link_wdata = slot_q;
        count_d    = count_q + CW'(1);
      end
      S_PF: begin
        first_d     = link_rdata;
        val_raddr   = link_rdata;
        link_we     = 1'b1;
        free_head_d = first_q;
        count_d     = count_q - CW'(1);
      end
      S_FVAL: front_val_d = val_rdata;
      S_PB: begin
        link_we     = 1'b1;
        link_waddr  = last_q;
        free_head_d = last_q;
        last_d      = cur_q;
        count_d     = count_q - CW'(1);
      end
      S_BVAL: back_val_d = val_rdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      first_q     <= '0;
      last_q      <= '0;
      free_head_q <= '0;
      count_q     <= '0;
      nu_q        <= '0;
      steps_q     <= '0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      last_q      <= last_d;
      free_head_q <= free_head_d;
      count_q     <= count_d;
      nu_q        <= nu_d;
      steps_q     <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && start_i) begin
      act_q <= action_i;
      val_q <= value_i;
      pos_q <= position_i;
    end
    status_q    <= status_d;
    cur_q       <= cur_d;
    slot_q      <= slot_d;
    front_val_q <= front_val_d;
    back_val_q  <= back_val_d;
  end

  // value memory
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_in;
    end
    val_rdata <= val_mem[val_raddr];
  end

  // link memory
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[link_raddr];
  end

  assign front_ext = 64'(signed'(front_val_q));
  assign back_ext  = 64'(signed'(back_val_q));

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = (state_q == S_RESP);
  assign status_o      = status_q;
  assign length_o      = LENGTH_W'(count_q);
  assign front_value_o = is_empty ? '0 : front_ext[VALUE_W-1:0];
  assign back_value_o  = is_empty ? '0 : back_ext[VALUE_W-1:0];

endmodule

`default_nettype wire

// ----- tb/ole_result_checker.sv -----
// result checker for the ordered list engine: tracks the list contents and compares every result
module ole_result_checker #(
  parameter int unsigned CAPACITY = ole_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  logic [ole_pkg::ACTION_W-1:0]        action_i,
  input  logic signed [ole_pkg::VALUE_W-1:0]  value_i,
  input  logic [ole_pkg::POSITION_W-1:0]      position_i,
  input  logic                                done_i,
  input  logic [ole_pkg::STATUS_W-1:0]        status_i,
  input  logic [ole_pkg::LENGTH_W-1:0]        length_i,
  input  logic signed [ole_pkg::VALUE_W-1:0]  front_value_i,
  input  logic signed [ole_pkg::VALUE_W-1:0]  back_value_i,
  input  logic                                finish_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ole_pkg::*;

  localparam int MAX_PRINTED = 200;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [LENGTH_W-1:0]       length;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] back_value;
  } list_result_t;

  logic signed [VALUE_W-1:0] stored_values[$];
  list_result_t              expected_results[$];
  list_result_t              oldest;
  int                        printed_lines = 0;
  bit                        end_checked = 1'b0;

  function automatic list_result_t apply_command(input logic [ACTION_W-1:0] act,
                                                 input logic signed [VALUE_W-1:0] val,
                                                 input logic [POSITION_W-1:0] pos);
    list_result_t res;
    res.status = ST_OK;
    case (act)
      ACT_PUSH_FRONT: begin
        if (stored_values.size() >= CAPACITY) res.status = ST_FULL;
        else stored_values.insert(0, val);
      end
      ACT_PUSH_BACK: begin
        if (stored_values.size() >= CAPACITY) res.status = ST_FULL;
        else stored_values.insert(stored_values.size(), val);
      end
      ACT_POP_FRONT: begin
        if (stored_values.size() == 0) res.status = ST_EMPTY;
        else stored_values.delete(0);
      end
      ACT_POP_BACK: begin
        if (stored_values.size() == 0) res.status = ST_EMPTY;
        else stored_values.delete(stored_values.size() - 1);
      end
      ACT_INSERT: begin
        // position check comes before the full check
        if (int'(pos) > stored_values.size()) res.status = ST_INVALID;
        else if (stored_values.size() >= CAPACITY) res.status = ST_FULL;
        else if (int'(pos) == stored_values.size())
          stored_values.insert(stored_values.size(), val);
        else stored_values.insert(int'(pos), val);
      end
      default: res.status = ST_INVALID;
    endcase
    res.length = LENGTH_W'(stored_values.size());
    if (stored_values.size() == 0) begin
      res.front_value = '0;
      res.back_value  = '0;
    end else begin
      res.front_value = stored_values[0];
      res.back_value  = stored_values[$];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count_o++;
    if (printed_lines < MAX_PRINTED) begin
      printed_lines++;
      $display("[%0t] list result %s: got %0h, want %0h", $time, field, got, want);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_values.delete();
      expected_results.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("with no transaction pending", 32'(status_i), '0);
        end else begin
          oldest = expected_results[0];
          expected_results.delete(0);
          if (status_i !== oldest.status)
            report_mismatch("status", 32'(status_i), 32'(oldest.status));
          if (length_i !== oldest.length)
            report_mismatch("length", 32'(length_i), 32'(oldest.length));
          if (front_value_i !== oldest.front_value)
            report_mismatch("front value", front_value_i, oldest.front_value);
          if (back_value_i !== oldest.back_value)
            report_mismatch("back value", back_value_i, oldest.back_value);
        end
      end
      if (start_i && !busy_i)
        expected_results.insert(expected_results.size(),
                                apply_command(action_i, value_i, position_i));
      if (finish_i && !end_checked) begin
        end_checked = 1'b1;
        if (expected_results.size() != 0)
          report_mismatch("left without result", 32'(expected_results.size()), '0);
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

// ----- tb/ordered_list_engine_core_tb.sv -----
// testbench top for the ordered list engine: command stimulus, watchdog and verdict
module ordered_list_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ole_pkg::*;

  localparam int CAP            = CAPACITY_DEF;
  localparam int SMALL_LIMIT    = 20;
  localparam int PHASE_ITEMS    = 280;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int TAIL_CYCLES    = 1100;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [ACTION_W-1:0]        action = '0;
  logic signed [VALUE_W-1:0]  value = '0;
  logic [POSITION_W-1:0]      position = '0;
  logic                       done;
  logic [STATUS_W-1:0]        status;
  logic [LENGTH_W-1:0]        length;
  logic signed [VALUE_W-1:0]  front_value;
  logic signed [VALUE_W-1:0]  back_value;
  logic                       finish_check = 1'b0;
  int                         fail_count;
  int                         pending;
  int                         list_len = 0;
  int                         stall_cycles = 0;

  ordered_list_engine_core #(
    .CAPACITY   (CAP),
    .VALUE_BITS (VALUE_BITS_DEF)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_o        (busy),
    .action_i      (action),
    .value_i       (value),
    .position_i    (position),
    .done_o        (done),
    .status_o      (status),
    .length_o      (length),
    .front_value_o (front_value),
    .back_value_o  (back_value)
  );

  ole_result_checker #(
    .CAPACITY (CAP)
  ) result_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .action_i      (action),
    .value_i       (value),
    .position_i    (position),
    .done_i        (done),
    .status_i      (status),
    .length_i      (length),
    .front_value_i (front_value),
    .back_value_i  (back_value),
    .finish_i      (finish_check),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || done) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("ordered_list_engine_core: mismatch");
          $finish;
        end
      end
    end
  end

  // one transaction; returns at the edge that accepts it, start left high
  task automatic issue_command(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val,
                               input logic [POSITION_W-1:0] pos);
    start    <= 1'b1;
    action   <= act;
    value    <= val;
    position <= pos;
    do @(posedge clk); while (busy);
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: if (list_len < CAP) list_len++;
      ACT_POP_FRONT, ACT_POP_BACK:   if (list_len > 0) list_len--;
      ACT_INSERT:                    if (int'(pos) <= list_len && list_len < CAP) list_len++;
      default: ;
    endcase
  endtask

  task automatic sender_gap(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POSITION_W-1:0] pick_insert_position(input int upto);
    if ($urandom_range(99) < 85) return POSITION_W'($urandom_range(upto, 0));
    return POSITION_W'($urandom_range(2047, upto + 1));
  endfunction

  task automatic random_item();
    logic [ACTION_W-1:0]   act;
    logic [POSITION_W-1:0] pos;
    pos = POSITION_W'($urandom_range(2047));
    case ($urandom_range(4))
      0:       act = ACT_PUSH_FRONT;
      1:       act = ACT_PUSH_BACK;
      2:       act = ACT_POP_FRONT;
      3:       act = ACT_POP_BACK;
      default: act = ACT_INSERT;
    endcase
    // keep the list short so the link walks stay cheap
    if (list_len >= SMALL_LIMIT && act inside {ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT}
        && $urandom_range(99) < 60)
      act = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
    if (list_len == 0 && act inside {ACT_POP_FRONT, ACT_POP_BACK} && $urandom_range(99) < 70)
      act = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_INSERT;
    if ($urandom_range(99) < 4) act = ACT_INSERT + ACTION_W'($urandom_range(3, 1));
    if (act == ACT_INSERT) pos = pick_insert_position(list_len);
    issue_command(act, pick_value(), pos);
  endtask

  task automatic full_list_episode(input int idle_pct);
    logic [POSITION_W-1:0] pos;
    while (list_len < CAP) begin
      sender_gap(idle_pct);
      case ($urandom_range(4))
        0: issue_command(ACT_PUSH_FRONT, pick_value(), POSITION_W'($urandom_range(2047)));
        1: issue_command(ACT_PUSH_BACK, pick_value(), POSITION_W'($urandom_range(2047)));
        2: issue_command(ACT_INSERT, pick_value(), '0);
        3: issue_command(ACT_INSERT, pick_value(), POSITION_W'(list_len));
        default: begin
          pos = POSITION_W'((list_len < 8) ? $urandom_range(list_len) : $urandom_range(8));
          issue_command(ACT_INSERT, pick_value(), pos);
        end
      endcase
    end
    issue_command(ACT_PUSH_FRONT, pick_value(), '0);
    issue_command(ACT_PUSH_BACK, pick_value(), '1);
    issue_command(ACT_INSERT, pick_value(), POSITION_W'(CAP));
    issue_command(ACT_INSERT, pick_value(), POSITION_W'(CAP + 1));
    issue_command(ACT_INSERT, pick_value(), POSITION_W'($urandom_range(2047, CAP + 1)));
    issue_command(ACT_POP_BACK, pick_value(), '0);
    issue_command(ACT_INSERT, pick_value(), POSITION_W'($urandom_range(CAP - 2, CAP - 100)));
    issue_command(ACT_INSERT, pick_value(), POSITION_W'(1));
    issue_command(ACT_POP_FRONT, pick_value(), '0);
    issue_command(ACT_INSERT, pick_value(), POSITION_W'(1));
    wait_for_results();
  endtask

  task automatic random_phase(input int idle_pct, input int items, input bit with_full_list);
    for (int i = 0; i < items; i++) begin
      if (with_full_list && i == items / 2) full_list_episode(idle_pct);
      if ($urandom_range(99) == 0) wait_for_results();
      sender_gap(idle_pct);
      random_item();
    end
    wait_for_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue_command(ACT_POP_FRONT, 32'h0000_0000, 11'd0);
    issue_command(ACT_POP_BACK, 32'hffff_ffff, 11'h7ff);
    issue_command(ACT_INSERT, 32'h1234_5678, 11'd1);
    issue_command(ACT_INSERT, 32'h7fff_ffff, 11'd0);
    issue_command(ACT_POP_BACK, 32'h0000_0000, 11'd0);
    issue_command(ACT_PUSH_BACK, 32'h8000_0000, 11'd0);
    issue_command(ACT_POP_FRONT, 32'h0000_0000, 11'd0);
    issue_command(ACT_PUSH_FRONT, 32'hffff_ffff, 11'h7ff);
    issue_command(ACT_PUSH_BACK, 32'h0000_0000, 11'd0);
    issue_command(ACT_INSERT, 32'h8000_0000, 11'd2);
    issue_command(ACT_INSERT, 32'h7fff_ffff, 11'd1);
    issue_command(ACT_INSERT, 32'h5555_5555, 11'd3);
    issue_command(ACT_INSERT, 32'haaaa_aaaa, 11'h7ff);
    issue_command(ACT_INSERT + 3'd1, 32'hffff_ffff, 11'd0);
    issue_command(ACT_INSERT + 3'd2, 32'h0000_0000, 11'h7ff);
    issue_command(ACT_INSERT + 3'd3, 32'h8000_0000, 11'd1);
    issue_command(ACT_POP_BACK, 32'h0000_0000, 11'd0);
    issue_command(ACT_POP_FRONT, 32'h0000_0000, 11'd0);
    issue_command(ACT_PUSH_FRONT, 32'h5555_5555, 11'h555);
    issue_command(ACT_PUSH_BACK, 32'haaaa_aaaa, 11'h2aa);
    issue_command(ACT_INSERT, 32'h0000_0001, 11'd0);
    wait_for_results();

    random_phase(27, PHASE_ITEMS, 1'b0);
    random_phase(48, PHASE_ITEMS, 1'b1);
    random_phase(0, PHASE_ITEMS, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    finish_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("ordered_list_engine_core: match");
    end else begin
      $display("ordered_list_engine_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ole_pkg.sv
rtl/core/ordered_list_engine_core.sv
tb/ole_result_checker.sv
tb/ordered_list_engine_core_tb.sv
